// ===== rtl/pi_speed_controller_macros.svh =====
// ---------------------------------------------------------------------------
// pi_speed_controller_macros.svh
// Assertion macros used by the checker file of the speed controller.
// ---------------------------------------------------------------------------
`ifndef PI_SPEED_CONTROLLER_MACROS_SVH
`define PI_SPEED_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PISC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PISC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pisc_pkg.sv =====
// ---------------------------------------------------------------------------
// pisc_pkg
// Widths, limits, register indexes and sequencer codes of the PI controller.
// ---------------------------------------------------------------------------
package pisc_pkg;

  // Field widths
  localparam int TGT_W    = 14;
  localparam int GAIN_W   = 8;
  localparam int PER_W    = 16;
  localparam int SPD_W    = 15;
  localparam int ERR_W    = 16;
  localparam int INT_W    = 12;
  localparam int DUTY_W   = 7;
  localparam int CMP_W    = 16;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 16;
  localparam int ACC_W    = 26;
  localparam int PROD_W   = DUTY_W + PER_W;
  localparam int CNT_W    = 4;
  localparam int STATE_W  = 3;

  // Limits
  localparam logic [INT_W-1:0]  INTEGRAL_LIMIT = 12'd3200;
  localparam int                OUTPUT_SHIFT   = 5;
  localparam logic [DUTY_W-1:0] DUTY_MAX       = 7'd100;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_TARGET = 2'd0;
  localparam logic [CFG_AW-1:0] REG_PGAIN  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_IGAIN  = 2'd2;
  localparam logic [CFG_AW-1:0] REG_PERIOD = 2'd3;

  // Reset values
  localparam logic [TGT_W-1:0]  TGT_RST    = 14'd0;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 8'd1;
  localparam logic [PER_W-1:0]  PER_RST    = 16'd50;

  // Sequencer states
  localparam logic [STATE_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [STATE_W-1:0] ST_PI    = 3'd1;
  localparam logic [STATE_W-1:0] ST_DUTY  = 3'd2;
  localparam logic [STATE_W-1:0] ST_SCALE = 3'd3;
  localparam logic [STATE_W-1:0] ST_DIV   = 3'd4;
  localparam logic [STATE_W-1:0] ST_HOLD  = 3'd5;

  // Last step of each serial phase
  localparam logic [CNT_W-1:0] PI_LAST    = 4'(GAIN_W - 1);
  localparam logic [CNT_W-1:0] SCALE_LAST = 4'(DUTY_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST   = 4'(CMP_W - 1);

endpackage

// ===== rtl/pi_speed_controller.sv =====
// ---------------------------------------------------------------------------
// pi_speed_controller
// PI speed regulator with integral clamp and PWM compare scaling.
// ---------------------------------------------------------------------------
// Usage:
//   Configuration is a plain write port (cfg_we, cfg_addr, cfg_wdata):
//   0 target speed, 1 proportional gain, 2 integral gain, 3 PWM period.
//   Write it only while the block is idle.
//   The input channel (in_valid/in_ready) carries one measured speed per
//   sample tick. The result channel (out_valid/out_ready) returns duty,
//   compare value, speed error and the updated integral for each sample.
// Processing sequence:
//   After the input transaction the block runs shift-add for the two gain
//   products (one gain bit per cycle), the duty clamp, shift-add for
//   duty*period and restoring division by 100 (one quotient bit per
//   cycle), then loads the output register, which raises out_valid.
//   A new sample is taken only after the previous result is loaded.
// Reset and stall:
//   Synchronous reset clears the integral and restores the register
//   defaults. A stalled result waits in the output register; the next
//   sample is accepted and worked on, and waits for the slot to free.
// ---------------------------------------------------------------------------
module pi_speed_controller (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [pisc_pkg::CFG_AW-1:0]            cfg_addr,
  input  logic [pisc_pkg::CFG_DW-1:0]            cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [pisc_pkg::SPD_W-1:0]      in_measured_speed,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [pisc_pkg::DUTY_W-1:0]            out_duty_percent,
  output logic [pisc_pkg::CMP_W-1:0]             out_compare_value,
  output logic signed [pisc_pkg::ERR_W-1:0]      out_speed_error,
  output logic [pisc_pkg::INT_W-1:0]             out_integral_value
);

  // Configuration
  logic [pisc_pkg::TGT_W-1:0]   target_r;
  logic [pisc_pkg::GAIN_W-1:0]  pgain_r;
  logic [pisc_pkg::GAIN_W-1:0]  igain_r;
  logic [pisc_pkg::PER_W-1:0]   period_r;

  // Control
  logic [pisc_pkg::STATE_W-1:0] state_r;
  logic [pisc_pkg::STATE_W-1:0] state_nxt;
  logic [pisc_pkg::CNT_W-1:0]   cnt_r;
  logic                         out_valid_r;

  // Datapath
  logic [pisc_pkg::INT_W-1:0]   error_sum_r;
  logic [pisc_pkg::ERR_W-1:0]   err_r;
  logic [pisc_pkg::ACC_W-1:0]   acc_r;
  logic [pisc_pkg::ACC_W-1:0]   mc_err_r;
  logic [pisc_pkg::ACC_W-1:0]   mc_int_r;
  logic [pisc_pkg::GAIN_W-1:0]  pg_sh_r;
  logic [pisc_pkg::GAIN_W-1:0]  ig_sh_r;
  logic [pisc_pkg::DUTY_W-1:0]  duty_r;
  logic [pisc_pkg::DUTY_W-1:0]  dsh_r;
  logic [pisc_pkg::PROD_W-1:0]  mc_per_r;
  logic [pisc_pkg::PROD_W-1:0]  prod_r;

  // Output register
  logic [pisc_pkg::DUTY_W-1:0]  o_duty_r;
  logic [pisc_pkg::CMP_W-1:0]   o_cmp_r;
  logic [pisc_pkg::ERR_W-1:0]   o_err_r;
  logic [pisc_pkg::INT_W-1:0]   o_int_r;

  logic                         in_fire;
  logic                         out_load;
  logic [pisc_pkg::ERR_W-1:0]   err_calc;
  logic [pisc_pkg::INT_W+4:0]   isum;
  logic [pisc_pkg::INT_W-1:0]   integ_new;
  logic [pisc_pkg::ACC_W-1:0]   acc_step;
  logic [pisc_pkg::ACC_W-1:0]   acc_shr;
  logic [pisc_pkg::DUTY_W-1:0]  duty_calc;
  logic [pisc_pkg::DUTY_W:0]    div_trial;
  logic                         div_bit;
  logic [pisc_pkg::DUTY_W-1:0]  div_rem;

  assign in_ready  = (state_r == pisc_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == pisc_pkg::ST_HOLD) && (!out_valid_r || out_ready);

  // Error and clamped integral, both narrow adds at the transaction
  assign err_calc = {target_r[pisc_pkg::TGT_W-1], target_r, 1'b0}
                  - {in_measured_speed[pisc_pkg::SPD_W-1], in_measured_speed};
  assign isum     = {5'b0, error_sum_r} + {err_calc[pisc_pkg::ERR_W-1], err_calc};

  always_comb begin
    if (isum[pisc_pkg::INT_W+4]) begin
      integ_new = '0;
    end else if (isum > {5'b0, pisc_pkg::INTEGRAL_LIMIT}) begin
      integ_new = pisc_pkg::INTEGRAL_LIMIT;
    end else begin
      integ_new = isum[pisc_pkg::INT_W-1:0];
    end
  end

  // One gain bit of each product per cycle
  assign acc_step = acc_r + (pg_sh_r[0] ? mc_err_r : '0) + (ig_sh_r[0] ? mc_int_r : '0);

  assign acc_shr = $unsigned($signed(acc_r) >>> pisc_pkg::OUTPUT_SHIFT);

  always_comb begin
    if (acc_r[pisc_pkg::ACC_W-1]) begin
      duty_calc = '0;
    end else if (acc_shr > {{(pisc_pkg::ACC_W-pisc_pkg::DUTY_W){1'b0}}, pisc_pkg::DUTY_MAX}) begin
      duty_calc = pisc_pkg::DUTY_MAX;
    end else begin
      duty_calc = acc_shr[pisc_pkg::DUTY_W-1:0];
    end
  end

  // Restoring division: remainder sits above the quotient in prod_r
  assign div_trial = {prod_r[pisc_pkg::PROD_W-1:pisc_pkg::CMP_W], prod_r[pisc_pkg::CMP_W-1]};
  assign div_bit   = (div_trial >= {1'b0, pisc_pkg::DUTY_MAX});
  assign div_rem   = div_bit ? pisc_pkg::DUTY_W'(div_trial - {1'b0, pisc_pkg::DUTY_MAX})
                             : div_trial[pisc_pkg::DUTY_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pisc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = pisc_pkg::ST_PI;
      end
      pisc_pkg::ST_PI: begin
        if (cnt_r == pisc_pkg::PI_LAST) state_nxt = pisc_pkg::ST_DUTY;
      end
      pisc_pkg::ST_DUTY: begin
        state_nxt = pisc_pkg::ST_SCALE;
      end
      pisc_pkg::ST_SCALE: begin
        if (cnt_r == pisc_pkg::SCALE_LAST) state_nxt = pisc_pkg::ST_DIV;
      end
      pisc_pkg::ST_DIV: begin
        if (cnt_r == pisc_pkg::DIV_LAST) state_nxt = pisc_pkg::ST_HOLD;
      end
      pisc_pkg::ST_HOLD: begin
        if (out_load) state_nxt = pisc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pisc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pisc_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      error_sum_r <= '0;
      target_r    <= pisc_pkg::TGT_RST;
      pgain_r     <= pisc_pkg::GAIN_RST;
      igain_r     <= pisc_pkg::GAIN_RST;
      period_r    <= pisc_pkg::PER_RST;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) begin
        cnt_r <= '0;
      end else if (state_r != pisc_pkg::ST_IDLE && state_r != pisc_pkg::ST_HOLD) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire) error_sum_r <= integ_new;
      if (cfg_we) begin
        unique case (cfg_addr)
          pisc_pkg::REG_TARGET: target_r <= cfg_wdata[pisc_pkg::TGT_W-1:0];
          pisc_pkg::REG_PGAIN:  pgain_r  <= cfg_wdata[pisc_pkg::GAIN_W-1:0];
          pisc_pkg::REG_IGAIN:  igain_r  <= cfg_wdata[pisc_pkg::GAIN_W-1:0];
          pisc_pkg::REG_PERIOD: period_r <= cfg_wdata[pisc_pkg::PER_W-1:0];
        endcase
      end
    end
  end

  // Serial datapath
  always_ff @(posedge clk) begin
    case (state_r)
      pisc_pkg::ST_IDLE: begin
        if (in_valid) begin
          err_r    <= err_calc;
          acc_r    <= '0;
          mc_err_r <= {{(pisc_pkg::ACC_W-pisc_pkg::ERR_W){err_calc[pisc_pkg::ERR_W-1]}},
                       err_calc};
          mc_int_r <= {{(pisc_pkg::ACC_W-pisc_pkg::INT_W){1'b0}}, integ_new};
          pg_sh_r  <= pgain_r;
          ig_sh_r  <= igain_r;
        end
      end
      pisc_pkg::ST_PI: begin
        acc_r    <= acc_step;
        mc_err_r <= {mc_err_r[pisc_pkg::ACC_W-2:0], 1'b0};
        mc_int_r <= {mc_int_r[pisc_pkg::ACC_W-2:0], 1'b0};
        pg_sh_r  <= {1'b0, pg_sh_r[pisc_pkg::GAIN_W-1:1]};
        ig_sh_r  <= {1'b0, ig_sh_r[pisc_pkg::GAIN_W-1:1]};
      end
      pisc_pkg::ST_DUTY: begin
        duty_r   <= duty_calc;
        dsh_r    <= duty_calc;
        mc_per_r <= {{pisc_pkg::DUTY_W{1'b0}}, period_r};
        prod_r   <= '0;
      end
      pisc_pkg::ST_SCALE: begin
        prod_r   <= prod_r + (dsh_r[0] ? mc_per_r : '0);
        mc_per_r <= {mc_per_r[pisc_pkg::PROD_W-2:0], 1'b0};
        dsh_r    <= {1'b0, dsh_r[pisc_pkg::DUTY_W-1:1]};
      end
      pisc_pkg::ST_DIV: begin
        prod_r <= {div_rem, prod_r[pisc_pkg::CMP_W-2:0], div_bit};
      end
      default: begin
      end
    endcase
    if (out_load) begin
      o_duty_r <= duty_r;
      o_cmp_r  <= prod_r[pisc_pkg::CMP_W-1:0];
      o_err_r  <= err_r;
      o_int_r  <= error_sum_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_duty_percent   = o_duty_r;
  assign out_compare_value  = o_cmp_r;
  assign out_speed_error    = $signed(o_err_r);
  assign out_integral_value = o_int_r;

endmodule

// ===== rtl/pisc_checker.sv =====
// ---------------------------------------------------------------------------
// pisc_checker
// Port-level checks of the speed controller, bound to the top level.
// ---------------------------------------------------------------------------
`include "pi_speed_controller_macros.svh"

module pisc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [pisc_pkg::DUTY_W-1:0]        out_duty_percent,
  input logic [pisc_pkg::CMP_W-1:0]         out_compare_value,
  input logic signed [pisc_pkg::ERR_W-1:0]  out_speed_error,
  input logic [pisc_pkg::INT_W-1:0]         out_integral_value
);

  // Hold a stalled result
  `PISC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_duty_percent) && $stable(out_compare_value) && $stable(out_speed_error) && $stable(out_integral_value), "result changed while stalled")

  `PISC_ASSERT_IMP(a_duty_range, out_valid, out_duty_percent <= pisc_pkg::DUTY_MAX, "duty above full scale")

  `PISC_ASSERT_IMP(a_int_range, out_valid, out_integral_value <= pisc_pkg::INTEGRAL_LIMIT, "integral above clamp")

  `PISC_ASSERT_IMP(a_zero_cmp, out_valid && (out_duty_percent == '0), out_compare_value == '0, "compare value with zero duty")

  // A sample keeps the block busy for the following cycle
  `PISC_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready, "ready straight after a transaction")

endmodule

bind pi_speed_controller pisc_checker u_pisc_checker (.*);
